// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/cfq_pkg.sv =====
// Types and codes shared by the ring-buffer queue modules.
`timescale 1ns / 1ps
package cfq_pkg;

	// Operation codes as they arrive on func
	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_DISPLAY = 2'd2
	} op_t;

	// Result status codes
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_DELETED  = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_ELEMENT  = 3'd4;

	// One classified request waiting for the executor
	typedef struct packed {
		logic               valid;
		op_t                op;
		logic signed [31:0] value;
	} cmd_t;

	// One result as driven by the executor
	typedef struct packed {
		logic               valid;
		logic [2:0]         status;
		logic signed [31:0] value;
		logic               last;
	} res_t;

endpackage

// ===== hw/rtl/cfq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module cfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/cfq_front.sv =====
// Front end: accepts requests, drops unused codes, buffers them in a two-entry queue.
`timescale 1ns / 1ps
module cfq_front import cfq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         func,
	input  logic signed [31:0] item_value,
	input  logic               pop,
	output logic               busy,
	output cmd_t               cmd
);

	logic [1:0]         count_q;
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	op_t                op_q    [2];
	logic signed [31:0] value_q [2];
	logic               known;
	logic               push;
	logic               do_pop;

	// Classify: only the three defined codes go on to the executor
	always_comb begin
		unique case (func)
			OP_INSERT, OP_DELETE, OP_DISPLAY: known = 1'b1;
			default:                          known = 1'b0;
		endcase
	end

	assign busy   = (count_q == 2'd2);
	assign push   = start && !busy && known;
	assign do_pop = pop && (count_q != 2'd0);

	assign cmd.valid = (count_q != 2'd0);
	assign cmd.op    = op_q[rd_ptr_q];
	assign cmd.value = value_q[rd_ptr_q];

	// Queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]    <= op_t'(func);
			value_q[wr_ptr_q] <= item_value;
		end
	end

endmodule

// ===== hw/rtl/cfq_back.sv =====
// Back end: owns head/tail state and storage, executes one request at a time.
`timescale 1ns / 1ps
module cfq_back import cfq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output logic       pop,
	input  logic       cfg_valid,
	input  logic [4:0] cfg_data,
	output res_t       res
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEL,
		S_DISP
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cap_q;
	logic [IW-1:0]      head_q;
	logic [IW-1:0]      tail_q;
	logic               empty_q;
	logic [IW-1:0]      idx_q;
	logic [CW-1:0]      cnt_q;
	logic               fin_q;

	logic [IW-1:0]      tail_nxt;
	logic [IW-1:0]      head_nxt;
	logic [IW-1:0]      idx_nxt;
	logic               ins_full;
	logic               we;
	logic [IW-1:0]      waddr;
	logic [IW-1:0]      raddr;
	logic [31:0]        rdata;

	// Advance an index, wrapping at the capacity in use
	function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] i,
		input logic [CW-1:0] cap);
		logic [IW:0] n;
		n = {1'b0, i} + (IW+1)'(1);
		return (n >= (IW+1)'(cap)) ? '0 : n[IW-1:0];
	endfunction

	assign tail_nxt = step_idx(tail_q, cap_q);
	assign head_nxt = step_idx(head_q, cap_q);
	assign idx_nxt  = step_idx(idx_q, cap_q);
	assign ins_full = !empty_q && (tail_nxt == head_q);

	// Storage access: writes on insert, reads at head or at the display cursor
	assign pop   = (state_q == S_IDLE) && cmd.valid;
	assign we    = pop && (cmd.op == OP_INSERT) && !ins_full;
	assign waddr = empty_q ? '0 : tail_nxt;
	assign raddr = (state_q == S_DISP) ? idx_nxt : head_q;

	cfq_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(cmd.value),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Executor state, queue indices, capacity register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cap_q     <= CW'(DEPTH);
			head_q    <= '0;
			tail_q    <= '0;
			empty_q   <= 1'b1;
			idx_q     <= '0;
			cnt_q     <= '0;
			fin_q     <= 1'b0;
			res.valid <= 1'b0;
			res.status <= ST_EMPTY;
			res.value <= '0;
			res.last  <= 1'b0;
		end else begin
			res.valid <= 1'b0;

			// capacity is clamped into 1..DEPTH on write
			if (cfg_valid) begin
				if (cfg_data == 5'd0) begin
					cap_q <= CW'(1);
				end else if (int'(cfg_data) > DEPTH) begin
					cap_q <= CW'(DEPTH);
				end else begin
					cap_q <= CW'(cfg_data);
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						unique case (cmd.op)
							OP_INSERT: begin
								res.valid <= 1'b1;
								res.last  <= 1'b1;
								if (ins_full) begin
									res.status <= ST_FULL;
									res.value  <= '0;
								end else begin
									res.status <= ST_INSERTED;
									res.value  <= cmd.value;
									if (empty_q) begin
										head_q  <= '0;
										tail_q  <= '0;
										empty_q <= 1'b0;
									end else begin
										tail_q <= tail_nxt;
									end
								end
							end
							OP_DELETE: begin
								if (empty_q) begin
									res.valid  <= 1'b1;
									res.status <= ST_EMPTY;
									res.value  <= '0;
									res.last   <= 1'b1;
								end else begin
									// head entry is read this cycle
									if (head_q == tail_q) begin
										head_q  <= '0;
										tail_q  <= '0;
										empty_q <= 1'b1;
									end else begin
										head_q <= head_nxt;
									end
									state_q <= S_DEL;
								end
							end
							OP_DISPLAY: begin
								if (empty_q) begin
									res.valid  <= 1'b1;
									res.status <= ST_EMPTY;
									res.value  <= '0;
									res.last   <= 1'b1;
								end else begin
									idx_q   <= head_q;
									fin_q   <= (head_q == tail_q);
									cnt_q   <= CW'(1);
									state_q <= S_DISP;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_DEL: begin
					res.valid  <= 1'b1;
					res.status <= ST_DELETED;
					res.value  <= rdata;
					res.last   <= 1'b1;
					state_q    <= S_IDLE;
				end
				S_DISP: begin
					// one element per cycle; the next read is already issued
					res.valid  <= 1'b1;
					res.status <= ST_ELEMENT;
					res.value  <= rdata;
					res.last   <= fin_q;
					if (fin_q) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_nxt;
						fin_q <= (idx_nxt == tail_q) ||
							(({1'b0, cnt_q} + (CW+1)'(1)) >= (CW+1)'(DEPTH));
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/circular_queue_fifo.sv =====
// Top level of the ring-buffer queue of signed 32-bit words.
`timescale 1ns / 1ps
// Ring-buffer queue. A request (func, item_value) is taken when start is high
// and busy is low; busy rises only when the two-entry request queue is full.
// Code 3 on func is taken and dropped. Results appear on status, result_value
// and last for exactly one cycle with result_valid high; the receiver cannot
// hold them off. The executor runs one request at a time from the request
// queue: insert and any full or empty answer are given straight from the idle
// state, delete passes through a second state for the registered read of the
// single storage read port, and display streams one element per cycle with
// last on the final one. Each accepted request waits in the request queue,
// and every result is registered before it appears. Capacity is
// written through cfg_valid/cfg_data (cfg_ready is always high), clamped to
// 1..DEPTH, and should only change while no request is pending.
module circular_queue_fifo import cfq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [31:0] item_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data,
	output logic               result_valid,
	output logic [2:0]         status,
	output logic signed [31:0] result_value,
	output logic               last
);

	cmd_t cmd;
	res_t res;
	logic pop;

	assign cfg_ready = 1'b1;

	cfq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.func      (func),
		.item_value(item_value),
		.pop       (pop),
		.busy      (busy),
		.cmd       (cmd)
	);

	cfq_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.pop      (pop),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.res      (res)
	);

	assign result_valid = res.valid;
	assign status       = res.status;
	assign result_value = res.value;
	assign last         = res.last;

endmodule

// ===== hw/rtl/cfq_checker.sv =====
// Port-level checks for the ring-buffer queue, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cfq_checker import cfq_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic [2:0]         status,
	input logic signed [31:0] result_value,
	input logic               last
);

	// only display elements may be followed by more results of the same request
	`ASSERT_NOW(a_single_last, result_valid && (status != ST_ELEMENT), last)

	// rejected and empty answers carry zero
	`ASSERT_NOW(a_reject_zero, result_valid && ((status == ST_FULL) || (status == ST_EMPTY)), result_value == 32'sd0)

	// a display stream continues in the very next cycle until its last element
	`ASSERT_NEXT(a_stream_gapless, result_valid && !last, result_valid && (status == ST_ELEMENT))

endmodule

bind circular_queue_fifo cfq_checker u_cfq_checker (.*);
